// ===== hdl/hltc_pkg.sv =====
// ----------------------------------------------------------------------------
// hltc_pkg
// Shared types and constants of the hashed LRU tag cache: key layout,
// hash constants, opcodes and the item carried from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package hltc_pkg;

   // Tag store size
   localparam int ENTRIES_DEFAULT = 8;

   // Field widths
   localparam int KEY_LO_W   = 21;
   localparam int KEY_HI_W   = 46;
   localparam int HASH_W     = 32;
   localparam int STAMP_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int OUT_IDX_W  = 3;
   localparam int KEY_FIELDS = 10;
   localparam int STEP_W     = 4;

   // FNV-1a 32-bit constants
   localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;

   // Front-to-back queue depth
   localparam int QUEUE_DEPTH = 2;

   // Configuration port: register index is paddr[2]
   localparam int         CSR_ADDR_W           = 3;
   localparam logic [0:0] CSR_IDX_CACHE_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      OP_LOOKUP     = 2'd0,
      OP_FILL       = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_UNUSED     = 2'd3
   } hltc_opcode_type;

   // Classified item handed from front to back
   typedef struct packed {
      hltc_opcode_type       opcode;
      logic [KEY_LO_W-1:0]   key_lo;
      logic [KEY_HI_W-1:0]   key_hi;
      logic [HASH_W-1:0]     key_hash;
      logic                  bypass;
   } hltc_item_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } hltc_queue_status_type;

endpackage : hltc_pkg

`default_nettype wire

// ===== hdl/hltc_front.sv =====
// ----------------------------------------------------------------------------
// hltc_front
// Accepts request beats, packs the key and runs the FNV-1a hash one field
// per cycle through a single 32x32 multiplier, then pushes the item.
// ----------------------------------------------------------------------------
`default_nettype none

module hltc_front
   import hltc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cache_enable,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [2:0]            req_draw_ops,
   input  wire logic [7:0]            req_bg_level,
   input  wire logic                  req_bg_flag,
   input  wire logic [7:0]            req_scene_num,
   input  wire logic                  req_spr_flag,
   input  wire logic [15:0]           req_glyph_tex,
   input  wire logic [3:0]            req_glyph_bits,
   input  wire logic [7:0]            req_glyph_opacity,
   input  wire logic [1:0]            req_fade_mode,
   input  wire logic [15:0]           req_fade_layers,
   input  wire hltc_queue_status_type q_status,
   output logic                       push,
   output hltc_item_type              push_item
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_HASH = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type     state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   hltc_opcode_type     opcode_ff, opcode_in;
   logic [KEY_LO_W-1:0] lo_ff, lo_in;
   logic [KEY_HI_W-1:0] hi_ff, hi_in;
   logic                bypass_ff, bypass_in;
   logic [HASH_W-1:0]   word;
   logic [HASH_W-1:0]   mix;
   logic [HASH_W-1:0]   product;

   assign req_ready = (state_ff == F_IDLE);

   // Select the key field for this hash step, zero extended
   always_comb begin
      case (step_ff)
         4'd0:    word = {29'd0, lo_ff[2:0]};
         4'd1:    word = {24'd0, lo_ff[10:3]};
         4'd2:    word = {31'd0, lo_ff[11]};
         4'd3:    word = {24'd0, lo_ff[19:12]};
         4'd4:    word = {31'd0, lo_ff[20]};
         4'd5:    word = {16'd0, hi_ff[15:0]};
         4'd6:    word = {28'd0, hi_ff[19:16]};
         4'd7:    word = {24'd0, hi_ff[27:20]};
         4'd8:    word = {30'd0, hi_ff[29:28]};
         4'd9:    word = {16'd0, hi_ff[45:30]};
         default: word = '0;
      endcase
   end

   // One FNV-1a round: xor, then multiply modulo 2^32
   assign mix     = hash_ff ^ word;
   assign product = mix * HASH_PRIME;

   // Sequence accept, hash rounds and push
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      hash_in   = hash_ff;
      opcode_in = opcode_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      bypass_in = bypass_ff;
      push      = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               opcode_in = hltc_opcode_type'(req_opcode);
               lo_in     = {req_spr_flag, req_scene_num, req_bg_flag,
                            req_bg_level, req_draw_ops};
               hi_in     = {req_fade_layers, req_fade_mode, req_glyph_opacity,
                            req_glyph_bits, req_glyph_tex};
               bypass_in = ~cache_enable;
               hash_in   = HASH_BASIS;
               step_in   = '0;
               state_in  = F_HASH;
            end
         end
         F_HASH: begin
            hash_in = product;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(KEY_FIELDS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            push = ~q_status.full;
            if (!q_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_item = '{opcode: opcode_ff, key_lo: lo_ff, key_hi: hi_ff,
                        key_hash: hash_ff, bypass: bypass_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      hash_ff   <= hash_in;
      opcode_ff <= opcode_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      bypass_ff <= bypass_in;
   end

endmodule : hltc_front

`default_nettype wire

// ===== hdl/hltc_queue.sv =====
// ----------------------------------------------------------------------------
// hltc_queue
// Short FIFO of classified items between the hash front and the tag back.
// ----------------------------------------------------------------------------
`default_nettype none

module hltc_queue
   import hltc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire hltc_item_type push_item,
   input  wire logic          pop,
   output hltc_item_type      head_item,
   output hltc_queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hltc_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_item    = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : hltc_queue

`default_nettype wire

// ===== hdl/hltc_back.sv =====
// ----------------------------------------------------------------------------
// hltc_back
// Tag store: for lookups and fills, sweeps the entries one per cycle for a
// match and the LRU victim, then applies the update and loads the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module hltc_back
   import hltc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hltc_queue_status_type q_status,
   input  wire hltc_item_type         head_item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_hit,
   output logic [OUT_IDX_W-1:0]       rsp_entry_index,
   output logic [HASH_W-1:0]          rsp_key_hash,
   output logic                       rsp_bypassed
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_SCAN  = 3'b010,
      B_APPLY = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   hltc_item_type       cur_ff, cur_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_idx_ff, found_idx_in;
   logic                inv_ff, inv_in;
   logic [IDX_W-1:0]    inv_idx_ff, inv_idx_in;
   logic                best_ff, best_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0]  best_stamp_ff, best_stamp_in;

   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [HASH_W-1:0]   hash_mem_ff  [ENTRIES];
   logic [KEY_LO_W-1:0] lo_mem_ff    [ENTRIES];
   logic [KEY_HI_W-1:0] hi_mem_ff    [ENTRIES];
   logic [STAMP_W-1:0]  stamp_mem_ff [ENTRIES];

   logic [STAMP_W-1:0]  use_cnt_ff, use_cnt_in;
   logic [COUNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]  miss_cnt_ff, miss_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [HASH_W-1:0]   rsp_hash_ff, rsp_hash_in;
   logic                rsp_byp_ff, rsp_byp_in;

   logic                ent_valid;
   logic                ent_match;
   logic [STAMP_W-1:0]  ent_stamp;
   logic [IDX_W-1:0]    victim;
   logic                out_free;
   logic                stamp_wr;
   logic                fill_wr;
   logic [IDX_W-1:0]    wr_idx;
   logic [STAMP_W-1:0]  next_stamp;

   // Entry under the sweep
   assign ent_valid = valid_ff[scan_ff];
   assign ent_stamp = stamp_mem_ff[scan_ff];
   assign ent_match = ent_valid && (hash_mem_ff[scan_ff] == cur_ff.key_hash)
                      && (lo_mem_ff[scan_ff] == cur_ff.key_lo)
                      && (hi_mem_ff[scan_ff] == cur_ff.key_hi);

   assign victim     = inv_ff ? inv_idx_ff : best_idx_ff;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign next_stamp = use_cnt_ff + STAMP_W'(1);
   assign pop        = (state_ff == B_IDLE) && !q_status.empty;

   // Take an item, sweep the entries, then apply and respond
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      inv_in        = inv_ff;
      inv_idx_in    = inv_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      valid_in      = valid_ff;
      use_cnt_in    = use_cnt_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_byp_in    = rsp_byp_ff;
      stamp_wr      = 1'b0;
      fill_wr       = 1'b0;
      wr_idx        = victim;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               cur_in   = head_item;
               scan_in  = '0;
               found_in = 1'b0;
               inv_in   = 1'b0;
               best_in  = 1'b0;
               if (!head_item.bypass && (head_item.opcode == OP_LOOKUP ||
                                         head_item.opcode == OP_FILL)) begin
                  state_in = B_SCAN;
               end else begin
                  state_in = B_APPLY;
               end
            end
         end
         B_SCAN: begin
            if (!found_ff && ent_match) begin
               found_in     = 1'b1;
               found_idx_in = scan_ff;
            end
            if (!inv_ff && !ent_valid) begin
               inv_in     = 1'b1;
               inv_idx_in = scan_ff;
            end
            if (ent_valid && (!best_ff || ent_stamp < best_stamp_ff)) begin
               best_in       = 1'b1;
               best_idx_in   = scan_ff;
               best_stamp_in = ent_stamp;
            end
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = B_APPLY;
            end
         end
         B_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = cur_ff.key_hash;
               rsp_byp_in   = cur_ff.bypass;
               rsp_hit_in   = 1'b0;
               rsp_idx_in   = '0;
               state_in     = B_IDLE;
               if (!cur_ff.bypass) begin
                  case (cur_ff.opcode)
                     OP_LOOKUP: begin
                        if (found_ff) begin
                           stamp_wr   = 1'b1;
                           wr_idx     = found_idx_ff;
                           use_cnt_in = next_stamp;
                           hit_cnt_in = hit_cnt_ff + COUNT_W'(1);
                           rsp_hit_in = 1'b1;
                           rsp_idx_in = OUT_IDX_W'(found_idx_ff);
                        end else begin
                           miss_cnt_in = miss_cnt_ff + COUNT_W'(1);
                           rsp_idx_in  = OUT_IDX_W'(victim);
                        end
                     end
                     OP_FILL: begin
                        stamp_wr         = 1'b1;
                        fill_wr          = 1'b1;
                        valid_in[victim] = 1'b1;
                        use_cnt_in       = next_stamp;
                        rsp_idx_in       = OUT_IDX_W'(victim);
                     end
                     OP_INVALIDATE: begin
                        valid_in   = '0;
                        use_cnt_in = '0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_key_hash    = rsp_hash_ff;
   assign rsp_bypassed    = rsp_byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         use_cnt_ff   <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         use_cnt_ff   <= use_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      inv_ff        <= inv_in;
      inv_idx_ff    <= inv_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_byp_ff    <= rsp_byp_in;
   end

   // Write the entry payload on fill, the stamp on fill or hit
   always_ff @(posedge clock) begin
      if (fill_wr) begin
         hash_mem_ff[wr_idx] <= cur_ff.key_hash;
         lo_mem_ff[wr_idx]   <= cur_ff.key_lo;
         hi_mem_ff[wr_idx]   <= cur_ff.key_hi;
      end
      if (stamp_wr) begin
         stamp_mem_ff[wr_idx] <= next_stamp;
      end
   end

endmodule : hltc_back

`default_nettype wire

// ===== hdl/hashed_lru_tag_cache.sv =====
// ----------------------------------------------------------------------------
// hashed_lru_tag_cache
// Fully associative LRU tag cache keyed by an FNV-1a hash of a ten-field key.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_*) carry an opcode (lookup, fill, invalidate all)
//   and the ten key fields. Each accepted beat yields exactly one response
//   beat (rsp_*) with hit, entry_index, key_hash and bypassed, in order.
//   The APB-style port holds cache_enable at address 0; write it only while
//   no request is in flight. With cache_enable low every beat bypasses.
// Front and back:
//   The front takes one beat at a time: the accept, ten hash rounds
//   through one 32x32 multiplier, and a push into a two-deep queue; it
//   takes no new beat until that push is done. The back sweeps the tag
//   entries one per cycle for lookups and fills, after the pop and before
//   the apply. Invalidate, unused opcode and bypassed beats skip the
//   sweep.
// Reset and stall:
//   Synchronous reset clears all valid bits and the use counter and sets
//   cache_enable. A stalled response holds in its register; the queue keeps
//   the front hashing until it fills, then req_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_lru_tag_cache
   import hltc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [2:0]            req_draw_ops,
   input  wire logic [7:0]            req_bg_level,
   input  wire logic                  req_bg_flag,
   input  wire logic [7:0]            req_scene_num,
   input  wire logic                  req_spr_flag,
   input  wire logic [15:0]           req_glyph_tex,
   input  wire logic [3:0]            req_glyph_bits,
   input  wire logic [7:0]            req_glyph_opacity,
   input  wire logic [1:0]            req_fade_mode,
   input  wire logic [15:0]           req_fade_layers,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_hit,
   output logic [OUT_IDX_W-1:0]       rsp_entry_index,
   output logic [HASH_W-1:0]          rsp_key_hash,
   output logic                       rsp_bypassed,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic                  cache_enable_ff, cache_enable_in;
   logic                  csr_write;
   logic                  push;
   logic                  pop;
   hltc_item_type         push_item;
   hltc_item_type         head_item;
   hltc_queue_status_type q_status;

   // Configuration register
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready
                      & (paddr[2] == CSR_IDX_CACHE_ENABLE);

   always_comb begin
      cache_enable_in = cache_enable_ff;
      if (csr_write) begin
         cache_enable_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_CACHE_ENABLE) begin
         prdata = {31'd0, cache_enable_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_enable_ff <= 1'b1;
      end else begin
         cache_enable_ff <= cache_enable_in;
      end
   end

   hltc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cache_enable      (cache_enable_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_draw_ops      (req_draw_ops),
      .req_bg_level      (req_bg_level),
      .req_bg_flag       (req_bg_flag),
      .req_scene_num     (req_scene_num),
      .req_spr_flag      (req_spr_flag),
      .req_glyph_tex     (req_glyph_tex),
      .req_glyph_bits    (req_glyph_bits),
      .req_glyph_opacity (req_glyph_opacity),
      .req_fade_mode     (req_fade_mode),
      .req_fade_layers   (req_fade_layers),
      .q_status          (q_status),
      .push              (push),
      .push_item         (push_item)
   );

   hltc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   hltc_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_entry_index (rsp_entry_index),
      .rsp_key_hash    (rsp_key_hash),
      .rsp_bypassed    (rsp_bypassed)
   );

   // A bypassed beat reports neither a hit nor an entry
   a_bypass_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bypassed |-> !rsp_hit && (rsp_entry_index == '0))
      else $error("bypassed response carries hit or entry index");

   // Front is busy hashing right after it takes a beat
   a_front_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front accepted a beat while hashing");

   // No response is pending right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

endmodule : hashed_lru_tag_cache

`default_nettype wire

// ===== tb/hltc_checker.sv =====
// ----------------------------------------------------------------------------
// hltc_checker
// Scoreboard for the hashed LRU tag cache. It watches the request, response
// and configuration ports and keeps its own copy of the tag store, the use
// counter and cache_enable. For every accepted request beat it computes the
// FNV-1a hash, the hit or victim slot and the bypass flag. Each response
// beat is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module hltc_checker
   import hltc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [2:0]            req_draw_ops,
   input  logic [7:0]            req_bg_level,
   input  logic                  req_bg_flag,
   input  logic [7:0]            req_scene_num,
   input  logic                  req_spr_flag,
   input  logic [15:0]           req_glyph_tex,
   input  logic [3:0]            req_glyph_bits,
   input  logic [7:0]            req_glyph_opacity,
   input  logic [1:0]            req_fade_mode,
   input  logic [15:0]           req_fade_layers,
   // response channel
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_hit,
   input  logic [OUT_IDX_W-1:0]  rsp_entry_index,
   input  logic [HASH_W-1:0]     rsp_key_hash,
   input  logic                  rsp_bypassed,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   // status for the testbench top
   output int                    fail_count,
   output int                    replies_pending,
   output int                    replies_checked,
   output int                    hit_total,
   output int                    miss_total,
   output int                    fill_total,
   output int                    bypass_total
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                 hit;
      logic [OUT_IDX_W-1:0] entry_index;
      logic [HASH_W-1:0]    key_hash;
      logic                 bypassed;
   } cache_reply_type;

   // Shadow tag store
   logic                line_valid [ENTRIES];
   logic [HASH_W-1:0]   line_hash  [ENTRIES];
   logic [KEY_LO_W-1:0] line_lo    [ENTRIES];
   logic [KEY_HI_W-1:0] line_hi    [ENTRIES];
   logic [STAMP_W-1:0]  line_stamp [ENTRIES];
   logic [STAMP_W-1:0]  use_ctr;
   logic                enable_q;

   cache_reply_type expected_replies[$];
   int err_tally, checked_tally, hits, misses, fills, bypasses;

   // Fold one key word into the running FNV-1a hash
   function automatic logic [HASH_W-1:0] fnv_round(logic [HASH_W-1:0] h,
                                                   logic [HASH_W-1:0] w);
      logic [HASH_W-1:0] x;
      x = h ^ w;
      return x * HASH_PRIME;
   endfunction

   // First invalid slot, else least stamp with lowest index on ties
   function automatic int pick_victim();
      int best;
      logic [STAMP_W-1:0] best_stamp;
      best = 0;
      best_stamp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!line_valid[i]) begin
            return i;
         end
         if (i == 0 || line_stamp[i] < best_stamp) begin
            best = i;
            best_stamp = line_stamp[i];
         end
      end
      return best;
   endfunction

   // Apply one request beat to the shadow store and return its reply
   function automatic cache_reply_type serve_request();
      cache_reply_type r;
      logic [HASH_W-1:0] h;
      logic [KEY_LO_W-1:0] lo;
      logic [KEY_HI_W-1:0] hi;
      int slot;
      h = HASH_BASIS;
      h = fnv_round(h, 32'(req_draw_ops));
      h = fnv_round(h, 32'(req_bg_level));
      h = fnv_round(h, 32'(req_bg_flag));
      h = fnv_round(h, 32'(req_scene_num));
      h = fnv_round(h, 32'(req_spr_flag));
      h = fnv_round(h, 32'(req_glyph_tex));
      h = fnv_round(h, 32'(req_glyph_bits));
      h = fnv_round(h, 32'(req_glyph_opacity));
      h = fnv_round(h, 32'(req_fade_mode));
      h = fnv_round(h, 32'(req_fade_layers));
      lo = {req_spr_flag, req_scene_num, req_bg_flag, req_bg_level, req_draw_ops};
      hi = {req_fade_layers, req_fade_mode, req_glyph_opacity, req_glyph_bits,
            req_glyph_tex};

      r = '0;
      r.key_hash = h;
      if (!enable_q) begin
         r.bypassed = 1'b1;
         bypasses++;
         return r;
      end

      case (hltc_opcode_type'(req_opcode))
         OP_LOOKUP: begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && line_valid[i] && line_hash[i] == h &&
                   line_lo[i] == lo && line_hi[i] == hi) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               use_ctr = use_ctr + STAMP_W'(1);
               line_stamp[slot] = use_ctr;
               r.hit = 1'b1;
               hits++;
            end else begin
               slot = pick_victim();
               misses++;
            end
            r.entry_index = OUT_IDX_W'(slot);
         end
         OP_FILL: begin
            slot = pick_victim();
            line_valid[slot] = 1'b1;
            line_hash[slot]  = h;
            line_lo[slot]    = lo;
            line_hi[slot]    = hi;
            use_ctr = use_ctr + STAMP_W'(1);
            line_stamp[slot] = use_ctr;
            r.entry_index = OUT_IDX_W'(slot);
            fills++;
         end
         OP_INVALIDATE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               line_valid[i] = 1'b0;
            end
            use_ctr = '0;
         end
         default: begin
            // unused opcode: no state change, no hit and entry index zero
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         err_tally++;
         $display("%0t ns: response %s mismatch, expected %0h, actual %0h",
                  $time, what, want, got);
      end
   endtask

   // Track config writes, queue predictions, check response beats
   always @(posedge clock) begin
      cache_reply_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_hash[i]  = '0;
            line_lo[i]    = '0;
            line_hi[i]    = '0;
            line_stamp[i] = '0;
         end
         use_ctr  = '0;
         enable_q = 1'b1;
         expected_replies.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_CACHE_ENABLE) begin
            enable_q = pwdata[0];
         end
         if (req_valid && req_ready) begin
            expected_replies.push_back(serve_request());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               err_tally++;
               $display("%0t ns: response beat with nothing expected, actual hash %0h",
                        $time, rsp_key_hash);
            end else begin
               want = expected_replies.pop_front();
               checked_tally++;
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("entry_index", 32'(want.entry_index), 32'(rsp_entry_index));
               check_field("key_hash", want.key_hash, rsp_key_hash);
               check_field("bypassed", 32'(want.bypassed), 32'(rsp_bypassed));
            end
         end
      end
      fail_count      <= err_tally;
      replies_pending <= expected_replies.size();
      replies_checked <= checked_tally;
      hit_total       <= hits;
      miss_total      <= misses;
      fill_total      <= fills;
      bypass_total    <= bypasses;
   end

endmodule : hltc_checker

// ===== tb/tb_hashed_lru_tag_cache.sv =====
// ----------------------------------------------------------------------------
// tb_hashed_lru_tag_cache
// Stimulus and verdict for the hashed LRU tag cache. A directed opening
// walks hits, misses, LRU eviction, invalidate, the unused opcode and the
// bypass mode; random phases then reuse a small key pool so lookups hit
// and fills evict, with cache_enable toggled and sender/receiver idling
// varied between phases. Checking is done by hltc_checker.
// ----------------------------------------------------------------------------
module tb_hashed_lru_tag_cache
   import hltc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE    = 12;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_PHASES   = 7;

   typedef struct packed {
      logic [2:0]  draw_ops;
      logic [7:0]  bg_level;
      logic        bg_flag;
      logic [7:0]  scene_num;
      logic        spr_flag;
      logic [15:0] glyph_tex;
      logic [3:0]  glyph_bits;
      logic [7:0]  glyph_opacity;
      logic [1:0]  fade_mode;
      logic [15:0] fade_layers;
   } frame_key_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode = '0;
   logic [2:0]            req_draw_ops = '0;
   logic [7:0]            req_bg_level = '0;
   logic                  req_bg_flag = 1'b0;
   logic [7:0]            req_scene_num = '0;
   logic                  req_spr_flag = 1'b0;
   logic [15:0]           req_glyph_tex = '0;
   logic [3:0]            req_glyph_bits = '0;
   logic [7:0]            req_glyph_opacity = '0;
   logic [1:0]            req_fade_mode = '0;
   logic [15:0]           req_fade_layers = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_hit;
   logic [OUT_IDX_W-1:0]  rsp_entry_index;
   logic [HASH_W-1:0]     rsp_key_hash;
   logic                  rsp_bypassed;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int fail_count, replies_pending, replies_checked;
   int hit_total, miss_total, fill_total, bypass_total;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   frame_key_type key_pool[POOL_SIZE];

   int phase_items   [NUM_PHASES] = '{130, 130, 60, 130, 130, 30, 40};
   int phase_idle    [NUM_PHASES] = '{0, 47, 0, 0, 34, 34, 0};
   int phase_stall   [NUM_PHASES] = '{0, 0, 47, 47, 34, 34, 0};
   logic phase_enable[NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

   hashed_lru_tag_cache dut (.*);

   hltc_checker scoreboard (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the response channel at the current phase's rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      #400000;
      $display("[hashed_lru_tag_cache] ERROR");
      $finish;
   end

   function automatic frame_key_type fresh_key();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return r[$bits(frame_key_type)-1:0];
   endfunction

   // Present one request beat, with random idle cycles ahead of it
   task automatic send_beat(hltc_opcode_type op, frame_key_type k);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_draw_ops      <= k.draw_ops;
      req_bg_level      <= k.bg_level;
      req_bg_flag       <= k.bg_flag;
      req_scene_num     <= k.scene_num;
      req_spr_flag      <= k.spr_flag;
      req_glyph_tex     <= k.glyph_tex;
      req_glyph_bits    <= k.glyph_bits;
      req_glyph_opacity <= k.glyph_opacity;
      req_fade_mode     <= k.fade_mode;
      req_fade_layers   <= k.fade_layers;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, wait out every reply, then let the back end settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(logic en);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_CACHE_ENABLE, 2'b00};
      pwdata  <= {31'($urandom), en};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly lookups and fills on pooled keys, some fresh keys and noise
   task automatic random_beat();
      hltc_opcode_type op;
      frame_key_type k;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 56)      op = OP_LOOKUP;
      else if (pick < 93) op = OP_FILL;
      else if (pick < 96) op = OP_INVALIDATE;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 99) < 8) begin
         key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
      end
      pick = $urandom_range(0, 99);
      if (pick < 10)      k = fresh_key();
      else if (pick < 80) k = key_pool[$urandom_range(0, 8)];
      else                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_beat(op, k);
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = fresh_key();
      end
      key_pool[0] = '0;
      key_pool[1] = '1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: miss, fill, hit on the all-zero key, fill and hit on the all-one key
      send_beat(OP_LOOKUP, key_pool[0]);
      send_beat(OP_FILL, key_pool[0]);
      send_beat(OP_LOOKUP, key_pool[0]);
      send_beat(OP_FILL, key_pool[1]);
      send_beat(OP_LOOKUP, key_pool[1]);
      // fill the remaining slots, refresh slot 1; slot 0 stays least recent
      for (int i = 2; i < 8; i++) begin
         send_beat(OP_FILL, key_pool[i]);
      end
      send_beat(OP_LOOKUP, key_pool[1]);
      // full store: miss picks the LRU victim, fill evicts it
      send_beat(OP_LOOKUP, key_pool[8]);
      send_beat(OP_FILL, key_pool[8]);
      send_beat(OP_LOOKUP, key_pool[0]);
      send_beat(OP_UNUSED, key_pool[1]);
      send_beat(OP_INVALIDATE, key_pool[2]);
      send_beat(OP_LOOKUP, key_pool[1]);
      send_beat(OP_FILL, key_pool[3]);

      // Directed: every opcode bypasses with the cache disabled
      wait_drained();
      write_enable(1'b0);
      send_beat(OP_LOOKUP, key_pool[3]);
      send_beat(OP_FILL, key_pool[4]);
      send_beat(OP_INVALIDATE, key_pool[5]);
      send_beat(OP_UNUSED, key_pool[6]);
      wait_drained();
      write_enable(1'b1);
      // the bypassed invalidate must have left this entry in place
      send_beat(OP_LOOKUP, key_pool[3]);

      // Random phases
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_enable(phase_enable[p]);
         sender_idle_pct = phase_idle[p];
         rsp_stall_pct   = phase_stall[p];
         for (int n = 0; n < phase_items[p]; n++) begin
            random_beat();
         end
      end

      wait_drained();
      $display("Run covered %0d responses: %0d hits, %0d misses, %0d fills, %0d bypassed,",
               replies_checked, hit_total, miss_total, fill_total, bypass_total);
      $display("across %0d random phases with cache_enable toggled and idling varied.",
               NUM_PHASES);
      if (fail_count == 0) begin
         $display("[hashed_lru_tag_cache] OK");
      end else begin
         $display("[hashed_lru_tag_cache] ERROR");
      end
      $finish;
   end

endmodule : tb_hashed_lru_tag_cache
